/* hw/rtl/svmps_pkg.sv */
// ----------------------------------------------------------------------------
// svmps_pkg
// Shared types and constants for the service-mode programming sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package svmps_pkg;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 3;

  // Probe position that stands for "verify the whole byte"
  localparam logic [3:0] ProbeByte = 4'd8;
  // Highest bit probed by a byte read
  localparam logic [3:0] ProbeTop  = 4'd7;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WBYTE = 2'd0,
    OP_WBIT  = 2'd1,
    OP_RBYTE = 2'd2,
    OP_RBIT  = 2'd3
  } op_e;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_OPERATION = 3'd0,
    REG_CV_NUMBER = 3'd1,
    REG_WR_VALUE  = 3'd2,
    REG_BIT_INDEX = 3'd3,
    REG_BIT_VALUE = 3'd4,
    REG_FIRST_RST = 3'd5,
    REG_CMD_RPT   = 3'd6,
    REG_TRAIL_RST = 3'd7
  } reg_idx_e;

  // Track packet kinds
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_RESET = 3'd1,
    KIND_WBYTE = 3'd2,
    KIND_WBIT  = 3'd3,
    KIND_VBIT  = 3'd4,
    KIND_VBYTE = 3'd5
  } kind_e;

  // Sequence phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_RESET1 = 4'b0010,
    PH_CMD    = 4'b0100,
    PH_RESET2 = 4'b1000
  } phase_e;

  typedef struct packed {
    op_e        operation;
    logic [10:0] cv_number;
    logic [7:0] write_value;
    logic [2:0] bit_index;
    logic       bit_value;
    logic [7:0] first_resets;
    logic [7:0] command_repeats;
    logic [7:0] trailing_resets;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic ack_seen;
  } item_t;

  typedef struct packed {
    kind_e       packet_kind;
    logic [10:0] packet_cv_number;
    logic [7:0]  packet_byte;
    logic [2:0]  packet_bit_index;
    logic        packet_bit_value;
    logic        rearm_ack;
    logic        busy_res;
    logic        finished;
    logic        success;
    logic [7:0]  result_value;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/svmps_cfg.sv */
// ----------------------------------------------------------------------------
// svmps_cfg
// Configuration register file; writes are dropped while an operation runs.
// ----------------------------------------------------------------------------
`default_nettype none

module svmps_cfg
  import svmps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire reg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                idle_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i && idle_i) begin
      unique case (cfg_idx_i)
        REG_OPERATION: cfg_d.operation       = op_e'(cfg_data_i[1:0]);
        REG_CV_NUMBER: cfg_d.cv_number       = cfg_data_i[10:0];
        REG_WR_VALUE:  cfg_d.write_value     = cfg_data_i[7:0];
        REG_BIT_INDEX: cfg_d.bit_index       = cfg_data_i[2:0];
        REG_BIT_VALUE: cfg_d.bit_value       = cfg_data_i[0];
        REG_FIRST_RST: cfg_d.first_resets    = cfg_data_i[7:0];
        REG_CMD_RPT:   cfg_d.command_repeats = cfg_data_i[7:0];
        REG_TRAIL_RST: cfg_d.trailing_resets = cfg_data_i[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operation       <= OP_WBYTE;
      cfg_q.cv_number       <= 11'd1;
      cfg_q.write_value     <= 8'd0;
      cfg_q.bit_index       <= 3'd0;
      cfg_q.bit_value       <= 1'b0;
      cfg_q.first_resets    <= 8'd20;
      cfg_q.command_repeats <= 8'd5;
      cfg_q.trailing_resets <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/svmps_seq.sv */
// ----------------------------------------------------------------------------
// svmps_seq
// Sequence state and the single-step logic that turns one word into a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module svmps_seq
  import svmps_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    res_o,
  output logic       idle_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [3:0] pbit_q, pbit_d;
  logic       pval_q, pval_d;
  logic [7:0] value_q, value_d;
  logic       ackg_q, ackg_d;
  logic       outc_q, outc_d;

  // Values after the acknowledge has been taken in
  phase_e     phase_m;
  logic [7:0] left_m;
  logic [7:0] value_m;
  logic       ackg_m;

  kind_e      kind;
  logic [7:0] pkt_byte;
  logic [2:0] pkt_bi;
  logic       pkt_bv;
  logic       rearm;
  logic       fin;
  logic       is_rb, is_rbit;

  assign is_rb   = (cfg_i.operation == OP_RBYTE);
  assign is_rbit = (cfg_i.operation == OP_RBIT);

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    pbit_d   = pbit_q;
    pval_d   = pval_q;
    value_d  = value_q;
    ackg_d   = ackg_q;
    outc_d   = outc_q;
    phase_m  = phase_q;
    left_m   = left_q;
    value_m  = value_q;
    ackg_m   = ackg_q;
    kind     = KIND_NONE;
    pkt_byte = 8'd0;
    pkt_bi   = 3'd0;
    pkt_bv   = 1'b0;
    rearm    = 1'b0;
    fin      = 1'b0;

    if (item_i.mode) begin
      // start, only taken while idle
      if (phase_q == PH_IDLE) begin
        phase_d = PH_RESET1;
        left_d  = cfg_i.first_resets;
        ackg_d  = 1'b0;
        outc_d  = 1'b0;
        value_d = 8'd0;
        pbit_d  = is_rbit ? {1'b0, cfg_i.bit_index} : 4'd0;
        pval_d  = 1'b0;
      end
    end else if (phase_q == PH_RESET1) begin
      // leading resets
      kind = KIND_RESET;
      if (left_q <= 8'd1) begin
        rearm   = 1'b1;
        phase_d = PH_CMD;
        left_d  = cfg_i.command_repeats;
        if (is_rb) begin
          pbit_d = ProbeTop;
          pval_d = 1'b1;
        end else if (is_rbit) begin
          pval_d = 1'b0;
        end
      end else begin
        left_d = left_q - 8'd1;
      end
    end else if (phase_q != PH_IDLE) begin
      // take in the acknowledge
      if (item_i.ack_seen) begin
        if (is_rb && !pbit_q[3]) begin
          value_m = value_q | (8'd1 << pbit_q[2:0]);
        end else begin
          phase_m = PH_RESET2;
          left_m  = 8'd0;
          ackg_m  = 1'b1;
          if (is_rbit) value_m = {7'd0, pval_q};
        end
      end
      value_d = value_m;
      ackg_d  = ackg_m;
      phase_d = phase_m;
      left_d  = left_m;

      priority if (phase_m == PH_CMD) begin
        // command run
        unique case (cfg_i.operation)
          OP_WBYTE: begin
            kind     = KIND_WBYTE;
            pkt_byte = cfg_i.write_value;
          end
          OP_WBIT: begin
            kind   = KIND_WBIT;
            pkt_bi = cfg_i.bit_index;
            pkt_bv = cfg_i.bit_value;
          end
          OP_RBYTE: begin
            if (pbit_q[3]) begin
              kind     = KIND_VBYTE;
              pkt_byte = value_m;
            end else begin
              kind   = KIND_VBIT;
              pkt_bi = pbit_q[2:0];
              pkt_bv = pval_q;
            end
          end
          default: begin
            kind   = KIND_VBIT;
            pkt_bi = pbit_q[2:0];
            pkt_bv = pval_q;
          end
        endcase
        if (left_m <= 8'd1) begin
          phase_d = PH_RESET2;
          left_d  = cfg_i.trailing_resets;
        end else begin
          left_d = left_m - 8'd1;
        end
      end else if (left_m != 8'd0) begin
        // trailing resets
        kind   = KIND_RESET;
        left_d = left_m - 8'd1;
        if (left_m == 8'd1 && is_rb) rearm = 1'b1;
      end else if (is_rb && pbit_q != 4'd0 && !pbit_q[3]) begin
        // next lower bit probe
        pbit_d = pbit_q - 4'd1;
        pval_d = 1'b1;
        kind   = KIND_VBIT;
        pkt_bi = pbit_d[2:0];
        pkt_bv = 1'b1;
        if (cfg_i.command_repeats <= 8'd1) begin
          phase_d = PH_RESET2;
          left_d  = cfg_i.trailing_resets;
        end else begin
          phase_d = PH_CMD;
          left_d  = cfg_i.command_repeats - 8'd1;
        end
      end else if (is_rb && pbit_q == 4'd0) begin
        // verify the assembled byte
        pbit_d   = ProbeByte;
        kind     = KIND_VBYTE;
        pkt_byte = value_m;
        if (cfg_i.command_repeats <= 8'd1) begin
          phase_d = PH_RESET2;
          left_d  = cfg_i.trailing_resets;
        end else begin
          phase_d = PH_CMD;
          left_d  = cfg_i.command_repeats - 8'd1;
        end
      end else if (is_rbit && !ackg_m && !pval_q) begin
        // bit read: no ack on 0, try 1
        pval_d  = 1'b1;
        kind    = KIND_VBIT;
        pkt_bi  = pbit_q[2:0];
        pkt_bv  = 1'b1;
        phase_d = PH_CMD;
        left_d  = cfg_i.command_repeats;
      end else begin
        // done
        outc_d  = ackg_m;
        phase_d = PH_IDLE;
        left_d  = 8'd0;
        fin     = 1'b1;
      end
    end
  end

  // Result word
  always_comb begin
    res_o.packet_kind      = kind;
    res_o.packet_cv_number = (kind == KIND_NONE || kind == KIND_RESET) ? 11'd0
                                                                      : cfg_i.cv_number;
    res_o.packet_byte      = pkt_byte;
    res_o.packet_bit_index = pkt_bi;
    res_o.packet_bit_value = pkt_bv;
    res_o.rearm_ack        = rearm;
    res_o.busy_res         = (phase_d != PH_IDLE);
    res_o.finished         = fin;
    res_o.success          = outc_d;
    res_o.result_value     = value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 8'd0;
      pbit_q  <= 4'd0;
      pval_q  <= 1'b0;
      value_q <= 8'd0;
      ackg_q  <= 1'b0;
      outc_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pbit_q  <= pbit_d;
      pval_q  <= pval_d;
      value_q <= value_d;
      ackg_q  <= ackg_d;
      outc_q  <= outc_d;
    end
  end

  assign idle_o = (phase_q == PH_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/service_mode_programming_sequencer.sv */
// ----------------------------------------------------------------------------
// service_mode_programming_sequencer
// Service-mode direct programming sequencer: at most one track packet per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (item_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (result_t)
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  A word is held in the input register, is stepped through the sequence
//  logic and lands in the output register; one word per cycle is sustained
//  while the output is not stalled. Reset clears the valid flags, the sequence
//  state and the configuration registers to their defaults. A stalled output
//  holds the output register and a full input register; an empty one still fills.
// ----------------------------------------------------------------------------
`default_nettype none

module service_mode_programming_sequencer
  import svmps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire item_t               in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output result_t                  out_data_o,
  input  wire logic                cfg_we_i,
  input  wire reg_idx_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  logic    adv;
  logic    fire;
  logic    idle;
  cfg_t    cfg;
  result_t res;

  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = adv && in_vld_q;
  assign in_ready_o = !in_vld_q || adv;

  svmps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .idle_i     (idle),
    .cfg_o      (cfg)
  );

  svmps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res),
    .idle_o (idle)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the service-mode programming sequencer. Words go in
// over a valid/ready channel with random gaps, results come out under random
// back-pressure. An in-bench model of the sequence predicts each result not
// typed into the table. A short table of hand-picked words opens the run; a
// long-count operation under one long output hold-off and random operations follow.
// ----------------------------------------------------------------------------
module tb_top
  import svmps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400_000;
  localparam int HoldCycles = 80;
  localparam int RandWords  = 200;

  // Bench signals; the inputs to the block are driven from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  item_t               in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  result_t             out_data_o;
  logic                cfg_we_i    = 1'b0;
  reg_idx_e            cfg_idx_i   = REG_OPERATION;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  service_mode_programming_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Sequencer model state and its copy of the registers
  cfg_t        cur_cfg;
  phase_e      seq_phase;
  logic [7:0]  pkts_left;
  logic [3:0]  probe_pos;
  logic        probe_val;
  logic [7:0]  read_val;
  logic        acked;
  logic        outcome;

  // Expected results, oldest first
  result_t     due_packets[$];

  // Hand-typed expectation for the word on the input, if any
  logic        fixed_check = 1'b0;
  result_t     fixed_result = '0;

  logic        idling = 1'b1;
  logic        hold_off_req = 1'b0;
  int          errors = 0;
  int          words_in = 0;
  int          results_in = 0;
  int          acked_ops = 0;
  int          op_count[4] = '{0, 0, 0, 0};
  int unsigned cycles = 0;

  typedef struct {
    logic    cfg_row;
    cfg_t    setting;
    item_t   word;
    logic    typed;
    result_t want;
  } script_row_t;

  script_row_t script[$];

  // Command packet with the current CV number filled in
  function automatic result_t cmd_packet(kind_e k, logic [7:0] b, logic [2:0] bi,
                                         logic bv);
    result_t r;
    r = '0;
    r.packet_kind      = k;
    r.packet_cv_number = cur_cfg.cv_number;
    r.packet_byte      = b;
    r.packet_bit_index = bi;
    r.packet_bit_value = bv;
    return r;
  endfunction

  // A command went out at the end of a trailing-reset run: continue the run
  function automatic void resume_cmd_run();
    if (cur_cfg.command_repeats <= 8'd1) begin
      seq_phase = PH_RESET2;
      pkts_left = cur_cfg.trailing_resets;
    end else begin
      seq_phase = PH_CMD;
      pkts_left = cur_cfg.command_repeats - 8'd1;
    end
  endfunction

  // One word through the sequence: returns the track packet and status
  function automatic result_t advance_sequencer(item_t w);
    result_t r;
    logic    rd_byte;
    logic    rd_bit;
    logic    rearm;
    logic    fin;
    rd_byte = (cur_cfg.operation == OP_RBYTE);
    rd_bit  = (cur_cfg.operation == OP_RBIT);
    rearm   = 1'b0;
    fin     = 1'b0;
    r       = '0;
    if (w.mode) begin
      // start only counts while idle
      if (seq_phase == PH_IDLE) begin
        seq_phase = PH_RESET1;
        pkts_left = cur_cfg.first_resets;
        acked     = 1'b0;
        outcome   = 1'b0;
        read_val  = '0;
        probe_pos = rd_bit ? {1'b0, cur_cfg.bit_index} : 4'd0;
        probe_val = 1'b0;
      end
    end else if (seq_phase == PH_RESET1) begin
      r.packet_kind = KIND_RESET;
      if (pkts_left <= 8'd1) begin
        rearm     = 1'b1;
        seq_phase = PH_CMD;
        pkts_left = cur_cfg.command_repeats;
        if (rd_byte) begin
          probe_pos = ProbeTop;
          probe_val = 1'b1;
        end else if (rd_bit) begin
          probe_val = 1'b0;
        end
      end else begin
        pkts_left = pkts_left - 8'd1;
      end
    end else if (seq_phase != PH_IDLE) begin
      // acknowledge: a probed bit is set, anything else ends the operation
      if (w.ack_seen) begin
        if (rd_byte && probe_pos < ProbeByte) begin
          read_val[probe_pos[2:0]] = 1'b1;
        end else begin
          seq_phase = PH_RESET2;
          pkts_left = '0;
          acked     = 1'b1;
          if (rd_bit) read_val = {7'd0, probe_val};
        end
      end
      if (seq_phase == PH_CMD) begin
        case (cur_cfg.operation)
          OP_WBYTE: r = cmd_packet(KIND_WBYTE, cur_cfg.write_value, 3'd0, 1'b0);
          OP_WBIT:  r = cmd_packet(KIND_WBIT, 8'd0, cur_cfg.bit_index, cur_cfg.bit_value);
          default: begin
            if (rd_byte && probe_pos >= ProbeByte) begin
              r = cmd_packet(KIND_VBYTE, read_val, 3'd0, 1'b0);
            end else begin
              r = cmd_packet(KIND_VBIT, 8'd0, probe_pos[2:0], probe_val);
            end
          end
        endcase
        if (pkts_left <= 8'd1) begin
          seq_phase = PH_RESET2;
          pkts_left = cur_cfg.trailing_resets;
        end else begin
          pkts_left = pkts_left - 8'd1;
        end
      end else if (pkts_left != 8'd0) begin
        r.packet_kind = KIND_RESET;
        pkts_left = pkts_left - 8'd1;
        if (pkts_left == 8'd0 && rd_byte) rearm = 1'b1;
      end else if (rd_byte && probe_pos >= 4'd1 && probe_pos <= ProbeTop) begin
        // next lower bit probe
        probe_pos = probe_pos - 4'd1;
        probe_val = 1'b1;
        r = cmd_packet(KIND_VBIT, 8'd0, probe_pos[2:0], 1'b1);
        resume_cmd_run();
      end else if (rd_byte && probe_pos == 4'd0) begin
        // all bits probed: verify the assembled byte
        probe_pos = ProbeByte;
        r = cmd_packet(KIND_VBYTE, read_val, 3'd0, 1'b0);
        resume_cmd_run();
      end else if (rd_bit && !acked && !probe_val) begin
        // no ack on zero, try one
        probe_val = 1'b1;
        r = cmd_packet(KIND_VBIT, 8'd0, probe_pos[2:0], 1'b1);
        seq_phase = PH_CMD;
        pkts_left = cur_cfg.command_repeats;
      end else begin
        outcome   = acked;
        seq_phase = PH_IDLE;
        pkts_left = '0;
        fin       = 1'b1;
      end
    end
    r.rearm_ack    = rearm;
    r.busy_res     = (seq_phase != PH_IDLE);
    r.finished     = fin;
    r.success      = outcome;
    r.result_value = read_val;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind=%0d cv=%0d byte=%02h bit=%0d/%0b rearm=%0b busy=%0b fin=%0b %s",
                     r.packet_kind, r.packet_cv_number, r.packet_byte, r.packet_bit_index,
                     r.packet_bit_value, r.rearm_ack, r.busy_res, r.finished,
                     $sformatf("ok=%0b val=%02h", r.success, r.result_value));
  endfunction

  // Status-only result, for rows typed into the table
  function automatic result_t plain(kind_e k, logic rearm, logic busy, logic fin, logic ok,
                                    logic [7:0] val);
    result_t r;
    r = '0;
    r.packet_kind  = k;
    r.rearm_ack    = rearm;
    r.busy_res     = busy;
    r.finished     = fin;
    r.success      = ok;
    r.result_value = val;
    return r;
  endfunction

  function automatic void add_cfg(cfg_t c);
    script_row_t row;
    row = '{1'b1, c, '0, 1'b0, '0};
    script = {script, row};
  endfunction

  function automatic void add_word(logic m, logic a);
    script_row_t row;
    row = '{1'b0, '0, item_t'{m, a}, 1'b0, '0};
    script = {script, row};
  endfunction

  function automatic void add_typed(logic m, logic a, result_t want);
    script_row_t row;
    row = '{1'b0, '0, item_t'{m, a}, 1'b1, want};
    script = {script, row};
  endfunction

  // Input side: offer one word, optionally after a gap, and wait for it to go in
  task automatic send_word(item_t w, logic typed, result_t want);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    fixed_check  = typed;
    fixed_result = want;
    in_valid_i  <= 1'b1;
    in_data_i   <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_packets.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_OPERATION, CfgDataW'(c.operation));
    write_reg(REG_CV_NUMBER, c.cv_number);
    write_reg(REG_WR_VALUE,  CfgDataW'(c.write_value));
    write_reg(REG_BIT_INDEX, CfgDataW'(c.bit_index));
    write_reg(REG_BIT_VALUE, CfgDataW'(c.bit_value));
    write_reg(REG_FIRST_RST, CfgDataW'(c.first_resets));
    write_reg(REG_CMD_RPT,   CfgDataW'(c.command_repeats));
    write_reg(REG_TRAIL_RST, CfgDataW'(c.trailing_resets));
    cfg_we_i <= 1'b0;
  endtask

  // Start, then request packets until the operation completes; stray starts
  // in between are ignored by the block and not counted
  task automatic run_op(input int ack_pct, inout int counted);
    send_word(item_t'{1'b1, 1'($urandom_range(0, 1))}, 1'b0, '0);
    counted++;
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 19) == 0)
        send_word(item_t'{1'b1, 1'($urandom_range(0, 1))}, 1'b0, '0);
      send_word(item_t'{1'b0, $urandom_range(0, 99) < ack_pct}, 1'b0, '0);
      counted++;
    end
  endtask

  // Output side: random stall bursts, plus one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_ready_i <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Register writes and accepted words feed the model; results are checked
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i && seq_phase == PH_IDLE) begin
        case (cfg_idx_i)
          REG_OPERATION: cur_cfg.operation       = op_e'(cfg_data_i[1:0]);
          REG_CV_NUMBER: cur_cfg.cv_number       = cfg_data_i;
          REG_WR_VALUE:  cur_cfg.write_value     = cfg_data_i[7:0];
          REG_BIT_INDEX: cur_cfg.bit_index       = cfg_data_i[2:0];
          REG_BIT_VALUE: cur_cfg.bit_value       = cfg_data_i[0];
          REG_FIRST_RST: cur_cfg.first_resets    = cfg_data_i[7:0];
          REG_CMD_RPT:   cur_cfg.command_repeats = cfg_data_i[7:0];
          REG_TRAIL_RST: cur_cfg.trailing_resets = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        if (in_data_i.mode && seq_phase == PH_IDLE) op_count[cur_cfg.operation]++;
        want = advance_sequencer(in_data_i);
        due_packets = {due_packets, (fixed_check ? fixed_result : want)};
        words_in++;
      end
      if (out_valid_o && out_ready_i) begin
        results_in++;
        if (due_packets.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word out: %s", show(out_data_o));
        end else begin
          want = due_packets.pop_front();
          if (out_data_o !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result %0d\n  exp %s\n  got %s", results_in, show(want),
                       show(out_data_o));
          end else if (want.finished && want.success) begin
            acked_ops++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               due_packets.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t setting;
    int   rand_words;
    int   ext_words;
    int   ack_choice[4];
    int   k;
    rand_words = 0;
    ext_words  = 0;
    ack_choice = '{0, 5, 25, 60};

    // register defaults and idle sequence after reset
    cur_cfg   = cfg_t'{OP_WBYTE, 11'd1, 8'd0, 3'd0, 1'b0, 8'd20, 8'd5, 8'd5};
    seq_phase = PH_IDLE;
    pkts_left = '0;
    probe_pos = '0;
    probe_val = 1'b0;
    read_val  = '0;
    acked     = 1'b0;
    outcome   = 1'b0;

    // Directed table: write byte with ack, write bit acked in its command run,
    // read bit that needs the second try, read byte that fails verification.
    // Zero counts and single-command runs are covered in the read operations.
    add_cfg(cfg_t'{OP_WBYTE, 11'd1024, 8'd255, 3'd7, 1'b1, 8'd1, 8'd2, 8'd1});
    add_typed(1'b0, 1'b1, plain(KIND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));  // idle request
    add_typed(1'b1, 1'b0, plain(KIND_NONE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));  // start
    add_typed(1'b1, 1'b1, plain(KIND_NONE, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0));  // start while busy
    add_typed(1'b0, 1'b0, plain(KIND_RESET, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0));
    add_word(1'b0, 1'b0);
    add_typed(1'b0, 1'b1, plain(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0));
    add_cfg(cfg_t'{OP_WBIT, 11'd1, 8'd0, 3'd7, 1'b1, 8'd1, 8'd2, 8'd1});
    add_word(1'b1, 1'b0);
    add_word(1'b0, 1'b0);
    add_word(1'b0, 1'b0);
    add_typed(1'b0, 1'b1, plain(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0));
    add_cfg(cfg_t'{OP_RBIT, 11'd1023, 8'd0, 3'd7, 1'b0, 8'd0, 8'd1, 8'd0});
    add_word(1'b1, 1'b0);
    add_word(1'b0, 1'b0);
    add_word(1'b0, 1'b0);
    add_word(1'b0, 1'b0);
    add_typed(1'b0, 1'b1, plain(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b1, 8'd1));
    add_cfg(cfg_t'{OP_RBYTE, 11'd1024, 8'd0, 3'd0, 1'b0, 8'd1, 8'd0, 8'd0});
    add_word(1'b1, 1'b0);
    add_word(1'b0, 1'b0);
    add_word(1'b0, 1'b1);                  // ack on the bit 7 probe
    repeat (8) add_word(1'b0, 1'b0);       // probes 6..0, then verify byte
    add_typed(1'b0, 1'b0, plain(KIND_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 8'h80));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].cfg_row) begin
        wait_drained();
        program_regs(script[i].setting);
      end else begin
        send_word(script[i].word, script[i].typed, script[i].want);
      end
    end

    // Long counts, never acknowledged; the output side holds off meanwhile
    wait_drained();
    program_regs(cfg_t'{OP_WBIT, 11'd1024, 8'd0, 3'd0, 1'b0, 8'd120, 8'd40, 8'd20});
    hold_off_req = 1'b1;
    run_op(0, ext_words);

    // Random operations with small counts and varied ack rates
    while (rand_words < RandWords) begin
      if (rand_words > RandWords - 80) idling = 1'b0;
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2))
          send_word(item_t'{1'b0, 1'($urandom_range(0, 1))}, 1'b0, '0);
      setting.operation       = op_e'($urandom_range(0, 3));
      setting.cv_number       = 11'($urandom_range(1, 1024));
      setting.write_value     = 8'($urandom);
      setting.bit_index       = 3'($urandom);
      setting.bit_value       = 1'($urandom);
      setting.first_resets    = 8'($urandom_range(1, 4));
      setting.command_repeats = 8'($urandom_range(2, 4));
      setting.trailing_resets = 8'($urandom_range(1, 3));
      if ($urandom_range(0, 7) == 0) setting.command_repeats = 8'($urandom_range(5, 24));
      wait_drained();
      program_regs(setting);
      run_op(ack_choice[$urandom_range(0, 3)], rand_words);
    end

    // Drain, with a bound, then wait out anything stray
    in_valid_i <= 1'b0;
    for (k = 0; k < 5000 && due_packets.size() != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (due_packets.size() != 0) begin
      errors++;
      $display("%0d expected results never came out", due_packets.size());
    end

    $display("%0d words in, %0d results checked, %0d mismatches, %0d cycles", words_in,
             results_in, errors, cycles);
    $display("ops: wr byte %0d, wr bit %0d, rd byte %0d, rd bit %0d; %0d acked; %0d-cycle hold",
             op_count[OP_WBYTE], op_count[OP_WBIT], op_count[OP_RBYTE], op_count[OP_RBIT],
             acked_ops, HoldCycles);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/svmps_pkg.sv
hw/rtl/svmps_cfg.sv
hw/rtl/svmps_seq.sv
hw/rtl/service_mode_programming_sequencer.sv
verif/tb_top.sv
